[design/spq_pkg.sv]
// ----------------------------------------------------------------------------
// Priority queue package
// Shared types, operation and status codes for the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int IP_W        = 32;
  localparam int PRIO_W      = 16;
  localparam int COUNT_OUT_W = 5;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 40;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [IP_W-1:0]          ip;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic rd_head;
    logic scan_start;
    logic rd_next;
    logic shift;
    logic place_init;
    logic place;
    logic capture;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_deq;
    logic empty;
    logic full;
    logic greater;
    logic last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[design/spq_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/spq_ctrl.sv]
// ----------------------------------------------------------------------------
// Priority queue controller
// Sequences the check, dequeue read, insertion walk and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire spq_pkg::sts_t sts,
  output spq_pkg::cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_DEQ    = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_PLACE  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.is_deq) begin
          if (sts.empty) begin
            state_next = ST_FINISH;
          end else begin
            cmd.rd_head = 1'b1;
            state_next  = ST_DEQ;
          end
        end else if (sts.full) begin
          state_next = ST_FINISH;
        end else if (sts.empty) begin
          cmd.place_init = 1'b1;
          state_next     = ST_PLACE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_DEQ: begin
        cmd.capture = 1'b1;
        state_next  = ST_FINISH;
      end
      ST_SCAN: begin
        if (sts.greater) begin
          cmd.shift = 1'b1;
          if (sts.last) begin
            state_next = ST_PLACE;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end else begin
          cmd.place  = 1'b1;
          state_next = ST_FINISH;
        end
      end
      ST_PLACE: begin
        cmd.place  = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/spq_dp.sv]
// ----------------------------------------------------------------------------
// Priority queue datapath
// Ring store with head and tail pointers, insertion walk and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_dp #(
  parameter int DEPTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire spq_pkg::cmd_t                      cmd,
  output spq_pkg::sts_t                           sts,
  input  wire logic [spq_pkg::IN_DATA_W-1:0]      s_tdata,
  input  wire logic                               s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic      [spq_pkg::OUT_DATA_W-1:0]     m_tdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  logic                         item_func;
  spq_pkg::entry_t              item;
  logic [AW-1:0]                head;
  logic [AW-1:0]                tail;
  logic [CW-1:0]                count;
  logic [CW-1:0]                count_next;
  logic [AW-1:0]                scan_ptr;
  logic [AW-1:0]                wr_ptr;
  logic [CW-1:0]                remaining;
  logic [spq_pkg::IP_W-1:0]     ip_res;
  logic [spq_pkg::IP_W-1:0]     out_ip;
  logic [1:0]                   out_status;
  logic [spq_pkg::COUNT_OUT_W-1:0] out_count;
  logic                         out_empty;
  logic [CW+spq_pkg::COUNT_OUT_W-1:0] count_ext;

  logic [AW-1:0]                tail_prev;
  logic [AW-1:0]                scan_prev;
  logic [AW-1:0]                rd_addr;
  logic                         ram_we;
  spq_pkg::entry_t              ram_wdata;
  spq_pkg::entry_t              rd_entry;
  logic [spq_pkg::ENTRY_W-1:0]  rd_bits;

  assign tail_prev = (tail == '0) ? LAST_ADDR : tail - 1'b1;
  assign scan_prev = (scan_ptr == '0) ? LAST_ADDR : scan_ptr - 1'b1;

  always_comb begin
    if (cmd.rd_head) begin
      rd_addr = head;
    end else if (cmd.scan_start) begin
      rd_addr = tail_prev;
    end else begin
      rd_addr = scan_prev;
    end
  end

  assign ram_we    = cmd.shift | cmd.place;
  assign ram_wdata = cmd.shift ? rd_entry : item;
  assign rd_entry  = spq_pkg::entry_t'(rd_bits);

  spq_ram #(
    .WIDTH (spq_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (rd_bits)
  );

  assign sts.is_deq   = (item_func == spq_pkg::FUNC_DEQ);
  assign sts.empty    = (count == '0);
  assign sts.full     = (count == CW'(DEPTH));
  assign sts.greater  = ($signed(rd_entry.prio) > $signed(item.prio));
  assign sts.last     = (remaining == CW'(1));
  assign sts.out_free = !m_tvalid || m_tready;

  always_comb begin
    count_next = count;
    if (sts.is_deq) begin
      if (!sts.empty) begin
        count_next = count - 1'b1;
      end
    end else if (!sts.full) begin
      count_next = count + 1'b1;
    end
  end

  assign count_ext = {{spq_pkg::COUNT_OUT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
        count    <= count_next;
        if (sts.is_deq) begin
          if (!sts.empty) begin
            head <= (head == LAST_ADDR) ? '0 : head + 1'b1;
          end
        end else if (!sts.full) begin
          tail <= (tail == LAST_ADDR) ? '0 : tail + 1'b1;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_func <= s_tuser;
      item.ip   <= s_tdata[31:0];
      item.prio <= s_tdata[47:32];
    end
    if (cmd.scan_start) begin
      scan_ptr  <= tail_prev;
      wr_ptr    <= tail;
      remaining <= count;
    end else if (cmd.place_init) begin
      wr_ptr <= tail;
    end else if (cmd.shift) begin
      wr_ptr    <= scan_ptr;
      remaining <= remaining - 1'b1;
      if (cmd.rd_next) begin
        scan_ptr <= scan_prev;
      end
    end
    if (cmd.capture) begin
      ip_res <= rd_entry.ip;
    end
    if (cmd.finish) begin
      out_ip    <= '0;
      out_count <= count_ext[spq_pkg::COUNT_OUT_W-1:0];
      out_empty <= (count_next == '0);
      if (sts.is_deq) begin
        if (sts.empty) begin
          out_status <= spq_pkg::STATUS_EMPTY;
        end else begin
          out_status <= spq_pkg::STATUS_OK;
          out_ip     <= ip_res;
        end
      end else if (sts.full) begin
        out_status <= spq_pkg::STATUS_FULL;
      end else begin
        out_status <= spq_pkg::STATUS_OK;
      end
    end
  end

  assign m_tdata = {out_empty, out_count, out_status, out_ip};

endmodule

`default_nettype wire

[design/stable_priority_queue.sv]
// ----------------------------------------------------------------------------
// Stable priority queue
// Min-first queue of addresses kept sorted by signed priority in a ring RAM;
// equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
//
//   Port group  Dir  tdata bits (low to high)                  tuser
//   s_*         in   ip_addr[31:0] priority_req[47:32]         func
//   m_*         out  ip_out[31:0] status[33:32]
//                    entry_count[38:34] is_empty[39]           none
//
// An enqueue shifts up every held entry with a higher priority number: the
// insertion walk moves one entry per cycle through the single read port of
// the store RAM.
// Reset empties the queue at once; the store needs no clearing pass.
// A stalled result holds in the output register; the next beat is taken
// meanwhile and waits only at its own hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // ip_addr, priority_req
  input  wire logic        s_tuser,  // func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata   // ip_out, status, entry_count, is_empty
);

  spq_pkg::cmd_t dp_cmd;
  spq_pkg::sts_t dp_sts;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  spq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (dp_cmd),
    .sts      (dp_sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

`ifndef SYNTH
  a_one_beat_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in flight");

  a_finish_needs_slot: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.finish |-> dp_sts.out_free)
    else $error("result loaded over a pending beat");

  a_single_write: assert property (@(posedge clk) disable iff (rst)
    !(dp_cmd.shift && dp_cmd.place))
    else $error("shift and place write in the same cycle");

  a_finish_raises_valid: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.finish |=> m_tvalid)
    else $error("finished item gave no result beat");
`endif

endmodule

`default_nettype wire

[tb/sv/tb_stable_priority_queue.sv]
// ----------------------------------------------------------------------------
// Stable priority queue testbench
// Drives enqueue and dequeue beats into the sorted queue, with ties, extreme
// priorities, empty and full cases, and random traffic under sender and
// receiver stalls. An in-order model predicts each result beat, and every
// accepted result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_stable_priority_queue;

  localparam int QDEPTH      = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  typedef logic [spq_pkg::PRIO_W-1:0]      prio_t;
  typedef logic [spq_pkg::COUNT_OUT_W-1:0] count_t;

  typedef struct packed {
    logic                            is_empty;
    logic [spq_pkg::COUNT_OUT_W-1:0] entry_count;
    logic [1:0]                      status;
    logic [spq_pkg::IP_W-1:0]        ip_out;
  } result_t;

  class spq_order_checker;
    spq_pkg::entry_t held_entries[$];
    result_t         pending_results[$];
    int              depth;
    int              errors;

    function new(int depth_i);
      depth  = depth_i;
      errors = 0;
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction

    function void take_request(logic func, logic [spq_pkg::IP_W-1:0] ip,
                               logic [spq_pkg::PRIO_W-1:0] prio);
      result_t         r;
      spq_pkg::entry_t e;
      int              pos;
      r = '0;
      if (func == spq_pkg::FUNC_ENQ) begin
        if (held_entries.size() >= depth) begin
          r.status = spq_pkg::STATUS_FULL;
        end else begin
          pos = held_entries.size();
          for (int i = 0; i < held_entries.size(); i++) begin
            if ($signed(held_entries[i].prio) > $signed(prio)) begin
              pos = i;
              break;
            end
          end
          e.ip   = ip;
          e.prio = prio;
          held_entries.insert(pos, e);
          r.status = spq_pkg::STATUS_OK;
        end
      end else begin
        if (held_entries.size() == 0) begin
          r.status = spq_pkg::STATUS_EMPTY;
        end else begin
          e        = held_entries.pop_front();
          r.ip_out = e.ip;
          r.status = spq_pkg::STATUS_OK;
        end
      end
      r.entry_count = count_t'(held_entries.size());
      r.is_empty    = (held_entries.size() == 0);
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_result(logic [spq_pkg::OUT_DATA_W-1:0] beat);
      result_t got;
      result_t want;
      got = beat;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat %h with no request outstanding", beat));
        return;
      end
      want = pending_results.pop_front();
      if (got.ip_out !== want.ip_out)
        report_mismatch($sformatf("ip_out %h, expected %h", got.ip_out, want.ip_out));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.entry_count !== want.entry_count)
        report_mismatch($sformatf("entry_count %0d, expected %0d",
                                  got.entry_count, want.entry_count));
      if (got.is_empty !== want.is_empty)
        report_mismatch($sformatf("is_empty %b, expected %b", got.is_empty, want.is_empty));
    endtask
  endclass

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [spq_pkg::IN_DATA_W-1:0]  s_tdata;   // ip_addr, priority_req
  logic                           s_tuser;   // func
  logic                           m_tvalid;
  logic                           m_tready;
  logic [spq_pkg::OUT_DATA_W-1:0] m_tdata;   // ip_out, status, entry_count, is_empty

  spq_order_checker checker_q;
  int               send_idle_pct;
  int               recv_idle_pct;
  bit               hold_request;
  int               cycle_count = 0;

  stable_priority_queue #(.DEPTH(QDEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) checker_q.check_result(m_tdata);
  end

  initial begin
    bit hold_done;
    hold_done = 1'b0;
    m_tready  = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the accept.
  task send_item(logic func, logic [spq_pkg::IP_W-1:0] ip,
                 logic [spq_pkg::PRIO_W-1:0] prio);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {prio, ip};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    checker_q.take_request(func, ip, prio);
    @(negedge clk);
  endtask

  task run_random(int n_items);
    int    sent;
    int    burst_len;
    int    enq_pct;
    int    pick;
    logic  func;
    prio_t prio;
    sent = 0;
    while (sent < n_items) begin
      burst_len = $urandom_range(40, 8);
      case ($urandom_range(2))
        0: enq_pct = 85;
        1: enq_pct = 20;
        default: enq_pct = 55;
      endcase
      for (int i = 0; i < burst_len && sent < n_items; i++) begin
        func = ($urandom_range(99) < enq_pct) ? spq_pkg::FUNC_ENQ : spq_pkg::FUNC_DEQ;
        pick = $urandom_range(9);
        if (pick < 4)
          prio = prio_t'(int'($urandom_range(6)) - 3);
        else if (pick == 4)
          prio = $urandom_range(1) ? 16'h7fff : 16'h8000;
        else
          prio = prio_t'($urandom());
        send_item(func, $urandom(), prio);
        sent++;
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = spq_pkg::FUNC_ENQ;
    hold_request = 1'b0;
    checker_q    = new(QDEPTH);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 33;
    recv_idle_pct = 81;
    send_item(spq_pkg::FUNC_DEQ, 32'h1234_5678, 16'h0000);
    send_item(spq_pkg::FUNC_ENQ, 32'h0000_0000, 16'h7fff);
    send_item(spq_pkg::FUNC_ENQ, 32'hffff_ffff, 16'h8000);
    send_item(spq_pkg::FUNC_ENQ, 32'h0a00_0001, 16'h0000);
    send_item(spq_pkg::FUNC_ENQ, 32'h0a00_0002, 16'h0000);
    send_item(spq_pkg::FUNC_ENQ, 32'hc0a8_0001, 16'hffff);
    send_item(spq_pkg::FUNC_ENQ, 32'h7f00_0001, 16'h7fff);
    send_item(spq_pkg::FUNC_ENQ, 32'h8000_0000, 16'h8000);
    send_item(spq_pkg::FUNC_ENQ, 32'h5555_aaaa, 16'h0001);
    repeat (8) send_item(spq_pkg::FUNC_DEQ, 32'hffff_ffff, 16'hffff);
    send_item(spq_pkg::FUNC_DEQ, 32'h0000_0000, 16'h8000);
    run_random(190);

    send_idle_pct = 81;
    recv_idle_pct = 33;
    run_random(200);

    // Long receiver stall while beats keep coming, so the input backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b1;
    run_random(200);
    s_tvalid <= 1'b0;

    while (checker_q.pending_count() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (checker_q.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
